// ----- src/date_time_stepper_with_autorepeat_core_defines.svh -----
// Assertion macros for the date and time stepper.
`ifndef DATE_TIME_STEPPER_WITH_AUTOREPEAT_CORE_DEFINES_SVH
`define DATE_TIME_STEPPER_WITH_AUTOREPEAT_CORE_DEFINES_SVH
`ifndef SYNTH
`define DTSA_ASSERT_IMP(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
    else $error(msg);
`define DTSA_ASSERT_NXT(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
    else $error(msg);
`else
`define DTSA_ASSERT_IMP(lbl, ck, rn, ant, con, msg)
`define DTSA_ASSERT_NXT(lbl, ck, rn, ant, con, msg)
`endif
`endif

// ----- src/dtsa_pkg.sv -----
`default_nettype none
package dtsa_pkg;

  localparam logic [11:0] YEAR_BASE_OUT     = 12'd2000;
  localparam logic [13:0] RAW_YEAR_LO       = 14'd2000;
  localparam logic [13:0] RAW_YEAR_HI       = 14'd2070;
  localparam logic [6:0]  YEAR_OFF_MAX      = 7'd69;
  localparam logic [6:0]  YEAR_OFF_FALLBACK = 7'd26;
  localparam logic [5:0]  MAX_STEPS         = 6'd32;
  localparam logic [16:0] HELD_TIME_MAX     = 17'h1FFFF;
  localparam logic [14:0] REPEAT_ACC_MAX    = 15'h7FFF;

  localparam logic [13:0] HOLD_DELAY_RST    = 14'd600;
  localparam logic [13:0] SLOW_RST          = 14'd200;
  localparam logic [13:0] FAST_RST          = 14'd100;
  localparam logic [15:0] RAMP_RST          = 16'd2000;

  localparam int unsigned PROD_W     = 30;
  localparam int unsigned DVSR_W     = 16;
  localparam int unsigned QUOT_W     = 14;
  localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W + 1);

  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;

  localparam logic [2:0] CFG_HOLD_DELAY = 3'd0;
  localparam logic [2:0] CFG_SLOW       = 3'd1;
  localparam logic [2:0] CFG_FAST       = 3'd2;
  localparam logic [2:0] CFG_RAMP       = 3'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_HOLD_ADD,
    OP_IVAL_FAST,
    OP_MUL,
    OP_DIV_START,
    OP_IVAL_RAMP,
    OP_ACC_ADD,
    OP_REP_STEP,
    OP_EMIT,
    OP_LOAD,
    OP_CLEAR,
    OP_NEW
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_IS_LOAD,
    C_IS_IDLE,
    C_IS_NEW,
    C_BELOW_DELAY,
    C_RAMP_DONE,
    C_DIV_BUSY,
    C_CAN_STEP,
    C_OUT_FULL
  } cond_t;

  typedef logic [4:0] upc_t;

  localparam upc_t UA_WAIT     = 5'd0;
  localparam upc_t UA_DISPATCH = 5'd1;
  localparam upc_t UA_IDLE_CHK = 5'd2;
  localparam upc_t UA_NEW_CHK  = 5'd3;
  localparam upc_t UA_HOLD     = 5'd4;
  localparam upc_t UA_DELAY    = 5'd5;
  localparam upc_t UA_FAST     = 5'd6;
  localparam upc_t UA_MUL      = 5'd7;
  localparam upc_t UA_DIV      = 5'd8;
  localparam upc_t UA_DIV_WAIT = 5'd9;
  localparam upc_t UA_RAMP     = 5'd10;
  localparam upc_t UA_ACC      = 5'd11;
  localparam upc_t UA_REPEAT   = 5'd12;
  localparam upc_t UA_OUT_WAIT = 5'd13;
  localparam upc_t UA_EMIT     = 5'd14;
  localparam upc_t UA_LOAD     = 5'd15;
  localparam upc_t UA_CLEAR    = 5'd16;
  localparam upc_t UA_NEW      = 5'd17;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  tgt;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic take;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic is_load;
    logic is_idle;
    logic is_new;
    logic below_delay;
    logic ramp_done;
    logic div_busy;
    logic can_step;
  } stat_t;

  typedef struct packed {
    logic        mode;
    logic        touching;
    logic [2:0]  field_sel;
    logic        up;
    logic [7:0]  elapsed_ms;
    logic [13:0] raw_year;
    logic [7:0]  raw_month;
    logic [7:0]  raw_day;
    logic [7:0]  raw_hour;
    logic [7:0]  raw_minute;
  } item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic [5:0]  steps;
  } res_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      UA_WAIT:     w = '{op: OP_NOP,       cond: C_NO_REQ,      tgt: UA_WAIT};
      UA_DISPATCH: w = '{op: OP_NOP,       cond: C_IS_LOAD,     tgt: UA_LOAD};
      UA_IDLE_CHK: w = '{op: OP_NOP,       cond: C_IS_IDLE,     tgt: UA_CLEAR};
      UA_NEW_CHK:  w = '{op: OP_NOP,       cond: C_IS_NEW,      tgt: UA_NEW};
      UA_HOLD:     w = '{op: OP_HOLD_ADD,  cond: C_NEVER,       tgt: UA_WAIT};
      UA_DELAY:    w = '{op: OP_NOP,       cond: C_BELOW_DELAY, tgt: UA_OUT_WAIT};
      UA_FAST:     w = '{op: OP_IVAL_FAST, cond: C_RAMP_DONE,   tgt: UA_ACC};
      UA_MUL:      w = '{op: OP_MUL,       cond: C_NEVER,       tgt: UA_WAIT};
      UA_DIV:      w = '{op: OP_DIV_START, cond: C_NEVER,       tgt: UA_WAIT};
      UA_DIV_WAIT: w = '{op: OP_NOP,       cond: C_DIV_BUSY,    tgt: UA_DIV_WAIT};
      UA_RAMP:     w = '{op: OP_IVAL_RAMP, cond: C_NEVER,       tgt: UA_WAIT};
      UA_ACC:      w = '{op: OP_ACC_ADD,   cond: C_NEVER,       tgt: UA_WAIT};
      UA_REPEAT:   w = '{op: OP_REP_STEP,  cond: C_CAN_STEP,    tgt: UA_REPEAT};
      UA_OUT_WAIT: w = '{op: OP_NOP,       cond: C_OUT_FULL,    tgt: UA_OUT_WAIT};
      UA_EMIT:     w = '{op: OP_EMIT,      cond: C_ALWAYS,      tgt: UA_WAIT};
      UA_LOAD:     w = '{op: OP_LOAD,      cond: C_ALWAYS,      tgt: UA_OUT_WAIT};
      UA_CLEAR:    w = '{op: OP_CLEAR,     cond: C_ALWAYS,      tgt: UA_OUT_WAIT};
      UA_NEW:      w = '{op: OP_NEW,       cond: C_ALWAYS,      tgt: UA_OUT_WAIT};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,      tgt: UA_WAIT};
    endcase
    return w;
  endfunction

  // Every year in range is 2000 plus the offset, so the leap rule reduces to the offset.
  function automatic logic [4:0] month_days(input logic [6:0] off, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                      d = (off[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] sak(input logic [3:0] m);
    logic [2:0] t;
    case (m)
      4'd1:    t = 3'd0;
      4'd2:    t = 3'd3;
      4'd3:    t = 3'd2;
      4'd4:    t = 3'd5;
      4'd5:    t = 3'd0;
      4'd6:    t = 3'd3;
      4'd7:    t = 3'd5;
      4'd8:    t = 3'd1;
      4'd9:    t = 3'd4;
      4'd10:   t = 3'd6;
      4'd11:   t = 3'd2;
      default: t = 3'd4;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [6:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {5'd0, x[7:6]} + {1'b0, x[5:0]};
    s2 = s1[6:3] + {1'b0, s1[2:0]};
    if (s2 >= 4'd14) begin
      r = s2 - 4'd14;
    end else if (s2 >= 4'd7) begin
      r = s2 - 4'd7;
    end else begin
      r = s2;
    end
    return r[2:0];
  endfunction

  // The century terms cancel over 1999 to 2069 and 2485 is a multiple of seven.
  function automatic logic [2:0] weekday_of(input logic [6:0] off, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [7:0] u;
    logic [7:0] s;
    u = {1'b0, off} + 8'd4 - {7'd0, (m < 4'd3)};
    s = u + {2'd0, u[7:2]} + {5'd0, sak(m)} + {3'd0, d} + 8'd2;
    return mod7(s);
  endfunction

endpackage
`default_nettype wire

// ----- src/dtsa_in_if.sv -----
`default_nettype none
interface dtsa_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        touching;
  logic [2:0]  field_sel;
  logic        up;
  logic [7:0]  elapsed_ms;
  logic [13:0] raw_year;
  logic [7:0]  raw_month;
  logic [7:0]  raw_day;
  logic [7:0]  raw_hour;
  logic [7:0]  raw_minute;

  modport source (
    output valid, mode, touching, field_sel, up, elapsed_ms,
           raw_year, raw_month, raw_day, raw_hour, raw_minute,
    input  ready
  );
  modport sink (
    input  valid, mode, touching, field_sel, up, elapsed_ms,
           raw_year, raw_month, raw_day, raw_hour, raw_minute,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/dtsa_out_if.sv -----
`default_nettype none
interface dtsa_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [2:0]  weekday;
  logic [5:0]  steps_taken;

  modport source (
    output valid, year_out, month_out, day_out, hour_out, minute_out,
           weekday, steps_taken,
    input  ready
  );
  modport sink (
    input  valid, year_out, month_out, day_out, hour_out, minute_out,
           weekday, steps_taken,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/dtsa_cfg_if.sv -----
`default_nettype none
interface dtsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/dtsa_div.sv -----
`default_nettype none
module dtsa_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [dtsa_pkg::PROD_W-1:0]     dividend,
  input  wire logic [dtsa_pkg::DVSR_W-1:0]     divisor,
  output logic                                 busy,
  output logic [dtsa_pkg::QUOT_W-1:0]          quotient
);

  localparam int unsigned DW = dtsa_pkg::DVSR_W;
  localparam int unsigned QW = dtsa_pkg::QUOT_W;
  localparam int unsigned CW = dtsa_pkg::DIV_CNT_W;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW+1:0] trial;

  // The quotient is known to fit, so the upper dividend bits already lie below the divisor.
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {1'b0, rem_r, q_r[QW-1]} - {2'b00, divisor};
    if (start) begin
      rem_nxt  = dividend[dtsa_pkg::PROD_W-1:QW];
      q_nxt    = dividend[QW-1:0];
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], q_r[QW-1]};
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ----- src/dtsa_dp.sv -----
`default_nettype none
module dtsa_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dtsa_pkg::ctrl_t ctrl,
  input  wire dtsa_pkg::item_t item,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_idx,
  input  wire logic [15:0]     cfg_data,
  output dtsa_pkg::stat_t      stat,
  output dtsa_pkg::res_t       res
);

  logic [13:0] hold_r, hold_nxt;
  logic [13:0] slow_r, slow_nxt;
  logic [13:0] fast_r, fast_nxt;
  logic [15:0] ramp_r, ramp_nxt;

  logic [6:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [2:0]  held_field_r, held_field_nxt;
  logic        held_up_r, held_up_nxt;
  logic [16:0] held_time_r, held_time_nxt;
  logic [14:0] acc_r, acc_nxt;
  logic [5:0]  steps_r, steps_nxt;

  dtsa_pkg::item_t item_r, item_nxt;
  logic [dtsa_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic        neg_r, neg_nxt;
  logic [13:0] ival_r, ival_nxt;

  logic [6:0]  st_year;
  logic [3:0]  st_month;
  logic [4:0]  st_day;
  logic [4:0]  st_hour;
  logic [5:0]  st_minute;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_new;

  logic [6:0]  ld_year;
  logic [3:0]  ld_month;
  logic [4:0]  ld_day;
  logic [4:0]  ld_dim;

  logic [16:0] prog;
  logic [13:0] abs_diff;
  logic [17:0] ht_sum;
  logic [15:0] acc_sum;
  logic [14:0] ival_sum;
  logic        can_step;
  logic        div_busy;
  logic [dtsa_pkg::QUOT_W-1:0] quot;

  dtsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.op == dtsa_pkg::OP_DIV_START),
    .dividend (prod_r),
    .divisor  (ramp_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // One field step of the held stepper, with the day clamped afterwards.
  always_comb begin
    st_year   = year_r;
    st_month  = month_r;
    st_day    = day_r;
    st_hour   = hour_r;
    st_minute = minute_r;
    dim_cur   = dtsa_pkg::month_days(year_r, month_r);
    case (item_r.field_sel)
      dtsa_pkg::FIELD_YEAR: begin
        if (item_r.up) begin
          st_year = (year_r >= dtsa_pkg::YEAR_OFF_MAX) ? 7'd0 : year_r + 7'd1;
        end else begin
          st_year = (year_r == 7'd0) ? dtsa_pkg::YEAR_OFF_MAX : year_r - 7'd1;
        end
      end
      dtsa_pkg::FIELD_MONTH: begin
        if (item_r.up) begin
          st_month = (month_r >= 4'd12) ? 4'd1 : month_r + 4'd1;
        end else begin
          st_month = (month_r <= 4'd1) ? 4'd12 : month_r - 4'd1;
        end
      end
      dtsa_pkg::FIELD_DAY: begin
        if (item_r.up) begin
          st_day = (day_r >= dim_cur) ? 5'd1 : day_r + 5'd1;
        end else begin
          st_day = (day_r <= 5'd1) ? dim_cur : day_r - 5'd1;
        end
      end
      dtsa_pkg::FIELD_HOUR: begin
        if (item_r.up) begin
          st_hour = (hour_r >= 5'd23) ? 5'd0 : hour_r + 5'd1;
        end else begin
          st_hour = (hour_r == 5'd0) ? 5'd23 : hour_r - 5'd1;
        end
      end
      default: begin
        if (item_r.up) begin
          st_minute = (minute_r >= 6'd59) ? 6'd0 : minute_r + 6'd1;
        end else begin
          st_minute = (minute_r == 6'd0) ? 6'd59 : minute_r - 6'd1;
        end
      end
    endcase
    dim_new = dtsa_pkg::month_days(st_year, st_month);
    if (st_day > dim_new) begin
      st_day = dim_new;
    end
  end

  always_comb begin
    if (item_r.raw_year < dtsa_pkg::RAW_YEAR_LO || item_r.raw_year >= dtsa_pkg::RAW_YEAR_HI) begin
      ld_year = dtsa_pkg::YEAR_OFF_FALLBACK;
    end else begin
      ld_year = 7'(item_r.raw_year - dtsa_pkg::RAW_YEAR_LO);
    end
    ld_month = (item_r.raw_month < 8'd1 || item_r.raw_month > 8'd12) ?
               4'd1 : item_r.raw_month[3:0];
    ld_day   = (item_r.raw_day < 8'd1 || item_r.raw_day > 8'd31) ?
               5'd1 : item_r.raw_day[4:0];
    ld_dim   = dtsa_pkg::month_days(ld_year, ld_month);
    if (ld_day > ld_dim) begin
      ld_day = ld_dim;
    end
  end

  always_comb begin
    prog     = held_time_r - {3'd0, hold_r};
    abs_diff = (fast_r < slow_r) ? slow_r - fast_r : fast_r - slow_r;
    ht_sum   = {1'b0, held_time_r} + {10'd0, item_r.elapsed_ms};
    acc_sum  = {1'b0, acc_r} + {8'd0, item_r.elapsed_ms};
    ival_sum = neg_r ? ({1'b0, slow_r} - {1'b0, quot}) : ({1'b0, slow_r} + {1'b0, quot});
    can_step = (steps_r < dtsa_pkg::MAX_STEPS) && ({1'b0, ival_r} <= acc_r);
  end

  always_comb begin
    hold_nxt       = hold_r;
    slow_nxt       = slow_r;
    fast_nxt       = fast_r;
    ramp_nxt       = ramp_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    hour_nxt       = hour_r;
    minute_nxt     = minute_r;
    held_valid_nxt = held_valid_r;
    held_field_nxt = held_field_r;
    held_up_nxt    = held_up_r;
    held_time_nxt  = held_time_r;
    acc_nxt        = acc_r;
    steps_nxt      = steps_r;
    item_nxt       = item_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    ival_nxt       = ival_r;

    if (cfg_we) begin
      case (cfg_idx)
        dtsa_pkg::CFG_HOLD_DELAY: hold_nxt = cfg_data[13:0];
        dtsa_pkg::CFG_SLOW:       slow_nxt = cfg_data[13:0];
        dtsa_pkg::CFG_FAST:       fast_nxt = cfg_data[13:0];
        dtsa_pkg::CFG_RAMP:       ramp_nxt = cfg_data;
        default: ;
      endcase
    end

    if (ctrl.take) begin
      item_nxt  = item;
      steps_nxt = 6'd0;
    end

    case (ctrl.op)
      dtsa_pkg::OP_HOLD_ADD: begin
        held_time_nxt = ht_sum[17] ? dtsa_pkg::HELD_TIME_MAX : ht_sum[16:0];
      end
      dtsa_pkg::OP_IVAL_FAST: begin
        ival_nxt = (fast_r == 14'd0) ? 14'd1 : fast_r;
      end
      dtsa_pkg::OP_MUL: begin
        neg_nxt  = fast_r < slow_r;
        prod_nxt = {16'd0, abs_diff} * {14'd0, prog[15:0]};
      end
      dtsa_pkg::OP_IVAL_RAMP: begin
        ival_nxt = (ival_sum[13:0] == 14'd0) ? 14'd1 : ival_sum[13:0];
      end
      dtsa_pkg::OP_ACC_ADD: begin
        acc_nxt = acc_sum[15] ? dtsa_pkg::REPEAT_ACC_MAX : acc_sum[14:0];
      end
      dtsa_pkg::OP_REP_STEP: begin
        if (can_step) begin
          acc_nxt    = acc_r - {1'b0, ival_r};
          year_nxt   = st_year;
          month_nxt  = st_month;
          day_nxt    = st_day;
          hour_nxt   = st_hour;
          minute_nxt = st_minute;
          steps_nxt  = steps_r + 6'd1;
        end
      end
      dtsa_pkg::OP_LOAD: begin
        year_nxt       = ld_year;
        month_nxt      = ld_month;
        day_nxt        = ld_day;
        hour_nxt       = (item_r.raw_hour > 8'd23) ? 5'd0 : item_r.raw_hour[4:0];
        minute_nxt     = (item_r.raw_minute > 8'd59) ? 6'd0 : item_r.raw_minute[5:0];
        held_valid_nxt = 1'b0;
        held_time_nxt  = 17'd0;
        acc_nxt        = 15'd0;
      end
      dtsa_pkg::OP_CLEAR: begin
        held_valid_nxt = 1'b0;
        held_time_nxt  = 17'd0;
        acc_nxt        = 15'd0;
      end
      dtsa_pkg::OP_NEW: begin
        held_valid_nxt = 1'b1;
        held_field_nxt = item_r.field_sel;
        held_up_nxt    = item_r.up;
        held_time_nxt  = 17'd0;
        acc_nxt        = 15'd0;
        year_nxt       = st_year;
        month_nxt      = st_month;
        day_nxt        = st_day;
        hour_nxt       = st_hour;
        minute_nxt     = st_minute;
        steps_nxt      = 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r       <= dtsa_pkg::HOLD_DELAY_RST;
      slow_r       <= dtsa_pkg::SLOW_RST;
      fast_r       <= dtsa_pkg::FAST_RST;
      ramp_r       <= dtsa_pkg::RAMP_RST;
      year_r       <= dtsa_pkg::YEAR_OFF_FALLBACK;
      month_r      <= 4'd1;
      day_r        <= 5'd1;
      hour_r       <= 5'd0;
      minute_r     <= 6'd0;
      held_valid_r <= 1'b0;
      held_field_r <= 3'd0;
      held_up_r    <= 1'b0;
      held_time_r  <= 17'd0;
      acc_r        <= 15'd0;
      steps_r      <= 6'd0;
    end else begin
      hold_r       <= hold_nxt;
      slow_r       <= slow_nxt;
      fast_r       <= fast_nxt;
      ramp_r       <= ramp_nxt;
      year_r       <= year_nxt;
      month_r      <= month_nxt;
      day_r        <= day_nxt;
      hour_r       <= hour_nxt;
      minute_r     <= minute_nxt;
      held_valid_r <= held_valid_nxt;
      held_field_r <= held_field_nxt;
      held_up_r    <= held_up_nxt;
      held_time_r  <= held_time_nxt;
      acc_r        <= acc_nxt;
      steps_r      <= steps_nxt;
    end
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    ival_r <= ival_nxt;
  end

  always_comb begin
    stat.is_load     = item_r.mode;
    stat.is_idle     = !item_r.touching || (item_r.field_sel > dtsa_pkg::FIELD_MINUTE);
    stat.is_new      = !held_valid_r || (held_field_r != item_r.field_sel) ||
                       (held_up_r != item_r.up);
    stat.below_delay = held_time_r < {3'd0, hold_r};
    stat.ramp_done   = (ramp_r == 16'd0) || (prog >= {1'b0, ramp_r});
    stat.div_busy    = div_busy;
    stat.can_step    = can_step;
  end

  always_comb begin
    res.year    = dtsa_pkg::YEAR_BASE_OUT + {5'd0, year_r};
    res.month   = month_r;
    res.day     = day_r;
    res.hour    = hour_r;
    res.minute  = minute_r;
    res.weekday = dtsa_pkg::weekday_of(year_r, month_r, day_r);
    res.steps   = steps_r;
  end

endmodule
`default_nettype wire

// ----- src/dtsa_seq.sv -----
`default_nettype none
module dtsa_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req,
  input  wire logic            out_full,
  input  wire dtsa_pkg::stat_t stat,
  output dtsa_pkg::ctrl_t      ctrl
);

  dtsa_pkg::upc_t   pc_r, pc_nxt;
  dtsa_pkg::uword_t uw;
  logic             jump;

  always_comb begin
    uw = dtsa_pkg::ucode(pc_r);
    case (uw.cond)
      dtsa_pkg::C_ALWAYS:      jump = 1'b1;
      dtsa_pkg::C_NO_REQ:      jump = !req;
      dtsa_pkg::C_IS_LOAD:     jump = stat.is_load;
      dtsa_pkg::C_IS_IDLE:     jump = stat.is_idle;
      dtsa_pkg::C_IS_NEW:      jump = stat.is_new;
      dtsa_pkg::C_BELOW_DELAY: jump = stat.below_delay;
      dtsa_pkg::C_RAMP_DONE:   jump = stat.ramp_done;
      dtsa_pkg::C_DIV_BUSY:    jump = stat.div_busy;
      dtsa_pkg::C_CAN_STEP:    jump = stat.can_step;
      dtsa_pkg::C_OUT_FULL:    jump = out_full;
      default:                 jump = 1'b0;
    endcase
    pc_nxt    = jump ? uw.tgt : pc_r + dtsa_pkg::upc_t'(1);
    ctrl.op   = uw.op;
    ctrl.idle = (pc_r == dtsa_pkg::UA_WAIT);
    ctrl.take = ctrl.idle && req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dtsa_pkg::UA_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/date_time_stepper_with_autorepeat_core.sv -----
// A request is a load, a release, a first press, a hold below the delay, or a repeat of n
// field steps, fully ramped or still ramping. While ramping, the ramp term of the interval
// comes from a radix-2 divider, and the field steps are then taken one at a time.
// One request is in work at a time; the next is taken the cycle after the result is posted.
// Synchronous active-low reset: date 2026-01-01 00:00, nothing held, registers to defaults.
`default_nettype none
`include "date_time_stepper_with_autorepeat_core_defines.svh"
module date_time_stepper_with_autorepeat_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dtsa_in_if.sink     in_ch,
  dtsa_out_if.source  out_ch,
  dtsa_cfg_if.sink    cfg_ch
);

  dtsa_pkg::ctrl_t ctrl;
  dtsa_pkg::stat_t stat;
  dtsa_pkg::item_t item;
  dtsa_pkg::res_t  res;
  dtsa_pkg::res_t  out_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_full;
  logic            emit;

  always_comb begin
    item.mode       = in_ch.mode;
    item.touching   = in_ch.touching;
    item.field_sel  = in_ch.field_sel;
    item.up         = in_ch.up;
    item.elapsed_ms = in_ch.elapsed_ms;
    item.raw_year   = in_ch.raw_year;
    item.raw_month  = in_ch.raw_month;
    item.raw_day    = in_ch.raw_day;
    item.raw_hour   = in_ch.raw_hour;
    item.raw_minute = in_ch.raw_minute;
  end

  assign out_full = out_valid_r && !out_ch.ready;
  assign emit     = (ctrl.op == dtsa_pkg::OP_EMIT);

  dtsa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_ch.valid),
    .out_full (out_full),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dtsa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .item     (item),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .stat     (stat),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign in_ch.ready        = ctrl.idle;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.year_out    = out_r.year;
  assign out_ch.month_out   = out_r.month;
  assign out_ch.day_out     = out_r.day;
  assign out_ch.hour_out    = out_r.hour;
  assign out_ch.minute_out  = out_r.minute;
  assign out_ch.weekday     = out_r.weekday;
  assign out_ch.steps_taken = out_r.steps;

  `DTSA_ASSERT_NXT(a_busy_after_take, clk, rst_n, ctrl.take, !in_ch.ready, "request taken but still ready")
  `DTSA_ASSERT_IMP(a_emit_into_free, clk, rst_n, emit, !out_valid_r, "result posted over a pending one")
  `DTSA_ASSERT_IMP(a_step_cap, clk, rst_n, out_valid_r, out_r.steps <= dtsa_pkg::MAX_STEPS, "step cap exceeded")

endmodule
`default_nettype wire
